>>> rtl/sukt_pkg.sv
// sorted unique key table: operation and status codes
`timescale 1ns / 1ps

package sukt_pkg;

    localparam int KEY_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;

endpackage

>>> rtl/sorted_unique_key_table_unit.sv
// Sorted unique key table: top level with key memory and operation sequencer
`timescale 1ns / 1ps

// Holds up to CAPACITY distinct signed 32-bit keys in ascending order in a
// single-port-read, single-port-write memory with a registered read port.
// Each input transfer inserts, deletes or searches one key and produces one
// result transfer with a status code and the entry count after the operation.
// One item is handled at a time. The sequencer scans the memory from entry 0,
// reading and then comparing each entry, until it meets a key not less
// than the requested one; an insert then moves the larger keys up and a
// delete moves them down, reading and then writing each moved entry. An
// insert ends by writing the new key into the freed entry; each item then
// passes through a result state and returns to the idle state, where the next
// input transfer is taken, and a result not yet accepted holds the next one
// in the result state. No clearing pass is needed after reset since only
// entries below the entry count are ever read.
module sorted_unique_key_table_unit #(
    parameter int CAPACITY = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [sukt_pkg::OP_W-1:0]         s_operation,
    input  logic signed [sukt_pkg::KEY_W-1:0] s_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [sukt_pkg::STATUS_W-1:0]     m_status,
    output logic [sukt_pkg::COUNT_W-1:0]      m_entry_count
);
    import sukt_pkg::*;

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int ADDR_W = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT_KEY,
        S_RESP
    } state_t;

    state_t               state_reg;
    logic [OP_W-1:0]      op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     sh_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [COUNT_W-1:0]   m_entry_count_reg;

    logic [KEY_W-1:0]     mem [CAPACITY];
    logic [KEY_W-1:0]     rd_data_reg;
    logic                 rd_en;
    logic [CNT_W-1:0]     rd_idx;
    logic                 wr_en;
    logic [CNT_W-1:0]     wr_idx;
    logic [KEY_W-1:0]     wr_data;

    logic                 key_less;
    logic                 scan_done;
    logic                 scan_match;

    // key memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx[ADDR_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx[ADDR_W-1:0]];
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_idx  = idx_reg;
        wr_en   = 1'b0;
        wr_idx  = sh_reg;
        wr_data = rd_data_reg;
        unique case (state_reg)
            S_SCAN_RD: begin
                rd_en  = (idx_reg < count_reg);
                rd_idx = idx_reg;
            end
            S_SHIFT_RD: begin
                rd_en  = 1'b1;
                rd_idx = (op_reg == OP_INSERT) ? sh_reg - 1'b1 : sh_reg + 1'b1;
            end
            S_SHIFT_WR: begin
                wr_en = 1'b1;
            end
            S_PUT_KEY: begin
                wr_en   = 1'b1;
                wr_idx  = idx_reg;
                wr_data = key_reg;
            end
            default: begin
            end
        endcase
    end

    assign key_less   = $signed(rd_data_reg) < $signed(key_reg);
    assign scan_match = (state_reg == S_SCAN_CHK) && (rd_data_reg == key_reg);
    assign scan_done  = ((state_reg == S_SCAN_RD) && !(idx_reg < count_reg))
                     || ((state_reg == S_SCAN_CHK) && !key_less);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // the result state reloads the output itself
            if (m_valid_reg && m_ready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_operation;
                        key_reg   <= s_key;
                        idx_reg   <= '0;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    if (idx_reg < count_reg) begin
                        state_reg <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (key_less) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SHIFT_RD: begin
                    state_reg <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    if (op_reg == OP_INSERT) begin
                        sh_reg <= sh_reg - 1'b1;
                        state_reg <= ((sh_reg - 1'b1) > idx_reg) ? S_SHIFT_RD : S_PUT_KEY;
                    end else begin
                        sh_reg <= sh_reg + 1'b1;
                        if (({1'b0, sh_reg} + (CNT_W+1)'(2)) < {1'b0, count_reg}) begin
                            state_reg <= S_SHIFT_RD;
                        end else begin
                            count_reg  <= count_reg - 1'b1;
                            status_reg <= ST_DELETED;
                            state_reg  <= S_RESP;
                        end
                    end
                end
                S_PUT_KEY: begin
                    count_reg  <= count_reg + 1'b1;
                    status_reg <= ST_INSERTED;
                    state_reg  <= S_RESP;
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg       <= 1'b1;
                        m_status_reg      <= status_reg;
                        m_entry_count_reg <= COUNT_W'(count_reg);
                        state_reg         <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase

            // scan has found the sorted position in idx_reg
            if (scan_done) begin
                unique case (op_reg)
                    OP_INSERT: begin
                        if (scan_match) begin
                            status_reg <= ST_DUPLICATE;
                            state_reg  <= S_RESP;
                        end else if (count_reg >= CNT_W'(CAPACITY)) begin
                            status_reg <= ST_FULL;
                            state_reg  <= S_RESP;
                        end else begin
                            sh_reg    <= count_reg;
                            state_reg <= (count_reg > idx_reg) ? S_SHIFT_RD : S_PUT_KEY;
                        end
                    end
                    OP_DELETE: begin
                        if (scan_match) begin
                            sh_reg <= idx_reg;
                            if ((idx_reg + 1'b1) < count_reg) begin
                                state_reg <= S_SHIFT_RD;
                            end else begin
                                count_reg  <= count_reg - 1'b1;
                                status_reg <= ST_DELETED;
                                state_reg  <= S_RESP;
                            end
                        end else begin
                            status_reg <= ST_NOT_FOUND;
                            state_reg  <= S_RESP;
                        end
                    end
                    OP_SEARCH: begin
                        status_reg <= scan_match ? ST_FOUND : ST_NOT_FOUND;
                        state_reg  <= S_RESP;
                    end
                    default: begin
                        status_reg <= ST_NOT_FOUND;
                        state_reg  <= S_RESP;
                    end
                endcase
            end
        end
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_entry_count_reg;

endmodule
